// ----- hw/rtl/tcss_pkg.sv -----
// ---------------------------------------------------------------------------
// tcss_pkg
// Shared types and constants of the tempo-locked chord step sequencer.
// ---------------------------------------------------------------------------
package tcss_pkg;

	localparam int MAX_CHORDS = 8;
	localparam int BEAT_WIDTH = 18;

	localparam int LEN_W   = 4;
	localparam int POS_W   = 3;
	localparam int BARS_W  = 3;
	localparam int PASS_W  = 4;
	localparam int CNT_W   = BEAT_WIDTH + 5;
	localparam int PROG_W  = 22;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [BEAT_WIDTH-1:0] BEAT_LENGTH_RST = BEAT_WIDTH'(29400);
	localparam logic [BARS_W-1:0]     BARS_RST        = BARS_W'(1);
	localparam logic [PASS_W-1:0]     ROLL_PASSES_RST = PASS_W'(2);
	localparam logic [PASS_W-1:0]     PASSES_MAX      = {PASS_W{1'b1}};
	localparam logic [LEN_W-1:0]      MAX_LEN         = LEN_W'(MAX_CHORDS);
	localparam logic [3:0]            POS_NONE        = 4'hF;

	typedef enum logic [2:0] {
		REG_BEAT_LENGTH      = 3'd0,
		REG_BARS_PER_CHORD   = 3'd1,
		REG_CLICK_ENABLE     = 3'd2,
		REG_AUTO_ROLL_ENABLE = 3'd3,
		REG_AUTO_ROLL_PASSES = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [BEAT_WIDTH-1:0] beat_length;
		logic [BARS_W-1:0]     bars_per_chord;
		logic                  click_enable;
		logic                  auto_roll_enable;
		logic [PASS_W-1:0]     auto_roll_passes;
	} cfg_t;

	typedef struct packed {
		logic             transport_on;
		logic             hold_time;
		logic             panic;
		logic             new_loop_valid;
		logic [LEN_W-1:0] new_loop_length;
		logic             jump_valid;
		logic [POS_W-1:0] jump_target;
	} item_t;

	typedef struct packed {
		logic              strike;
		logic [POS_W-1:0]  strike_index;
		logic              silence;
		logic              click;
		logic              click_accent;
		logic              roll_request;
		logic [3:0]        position;
		logic [PROG_W-1:0] chord_progress;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]      chord_sample_count;
		logic [BEAT_WIDTH-1:0] beat_sample_count;
		logic [POS_W-1:0]      chord_position;
		logic [PASS_W-1:0]     passes_done;
		logic [LEN_W-1:0]      loop_length;
		logic [LEN_W-1:0]      waiting_length;
		logic                  waiting_valid;
		logic                  roll_pending;
		logic                  was_playing;
	} state_t;

endpackage

// ----- hw/rtl/tempo_chord_step_sequencer.sv -----
// ---------------------------------------------------------------------------
// tempo_chord_step_sequencer
// Sample-rate chord step sequencer: counts beats and chords, strikes chords,
// flags clicks, silencing and auto-roll requests.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  apb       psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//  in        in_valid / in_ready       transport_on .. jump_target
//  out       out_valid / out_ready     strike .. chord_progress
//
//  One request per cycle unless the result stalls; requests pass the input and then the result register.
//  The input register feeds one pass of tick logic that updates the state
//  and loads the result register in the same edge.
//  Reset clears all counters and loop state; no clearing pass is needed.
//  A stalled result holds; the input register keeps taking requests until
//  it is full behind the held result.
// ---------------------------------------------------------------------------
module tempo_chord_step_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tcss_pkg::ADDR_W-1:0]       paddr,
	input  logic [tcss_pkg::DATA_W-1:0]       pwdata,
	output logic [tcss_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              transport_on,
	input  logic                              hold_time,
	input  logic                              panic,
	input  logic                              new_loop_valid,
	input  logic [tcss_pkg::LEN_W-1:0]        new_loop_length,
	input  logic                              jump_valid,
	input  logic [tcss_pkg::POS_W-1:0]        jump_target,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              strike,
	output logic [tcss_pkg::POS_W-1:0]        strike_index,
	output logic                              silence,
	output logic                              click,
	output logic                              click_accent,
	output logic                              roll_request,
	output logic signed [3:0]                 position,
	output logic [tcss_pkg::PROG_W-1:0]       chord_progress
);

	tcss_pkg::cfg_t    cfg;
	tcss_pkg::item_t   item_in;
	tcss_pkg::item_t   item_s1;
	logic              valid_s1;
	tcss_pkg::state_t  st_q;
	tcss_pkg::state_t  st_nxt;
	tcss_pkg::result_t res_nxt;
	tcss_pkg::result_t res_q;
	logic              out_valid_q;
	logic              advance;

	tcss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcss_core u_core (
		.cfg    (cfg),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	assign item_in.transport_on    = transport_on;
	assign item_in.hold_time       = hold_time;
	assign item_in.panic           = panic;
	assign item_in.new_loop_valid  = new_loop_valid;
	assign item_in.new_loop_length = new_loop_length;
	assign item_in.jump_valid      = jump_valid;
	assign item_in.jump_target     = jump_target;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				st_q        <= st_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign strike         = res_q.strike;
	assign strike_index   = res_q.strike_index;
	assign silence        = res_q.silence;
	assign click          = res_q.click;
	assign click_accent   = res_q.click_accent;
	assign roll_request   = res_q.roll_request;
	assign position       = res_q.position;
	assign chord_progress = res_q.chord_progress;

	a_accent_needs_click: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.click_accent |-> res_q.click)
		else $error("click accent without a click");

	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.strike |-> res_q.strike_index == '0)
		else $error("strike index set without a strike");

	a_strike_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.strike |-> res_q.position == {1'b0, res_q.strike_index})
		else $error("struck chord differs from reported position");

	a_roll_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.roll_request |=> st_q.roll_pending)
		else $error("roll request without pending flag");

endmodule

// ----- hw/rtl/tcss_cfg.sv -----
// ---------------------------------------------------------------------------
// tcss_cfg
// APB register file holding the tempo, bar, click and auto-roll settings.
// ---------------------------------------------------------------------------
module tcss_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tcss_pkg::ADDR_W-1:0] paddr,
	input  logic [tcss_pkg::DATA_W-1:0] pwdata,
	output logic [tcss_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output tcss_pkg::cfg_t             cfg
);

	tcss_pkg::cfg_t     cfg_q;
	tcss_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = tcss_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beat_length      <= tcss_pkg::BEAT_LENGTH_RST;
			cfg_q.bars_per_chord   <= tcss_pkg::BARS_RST;
			cfg_q.click_enable     <= 1'b0;
			cfg_q.auto_roll_enable <= 1'b0;
			cfg_q.auto_roll_passes <= tcss_pkg::ROLL_PASSES_RST;
		end else if (wr_en) begin
			case (idx)
				tcss_pkg::REG_BEAT_LENGTH: begin
					cfg_q.beat_length <= pwdata[tcss_pkg::BEAT_WIDTH-1:0];
				end
				tcss_pkg::REG_BARS_PER_CHORD: begin
					cfg_q.bars_per_chord <= pwdata[tcss_pkg::BARS_W-1:0];
				end
				tcss_pkg::REG_CLICK_ENABLE: begin
					cfg_q.click_enable <= pwdata[0];
				end
				tcss_pkg::REG_AUTO_ROLL_ENABLE: begin
					cfg_q.auto_roll_enable <= pwdata[0];
				end
				tcss_pkg::REG_AUTO_ROLL_PASSES: begin
					cfg_q.auto_roll_passes <= pwdata[tcss_pkg::PASS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			tcss_pkg::REG_BEAT_LENGTH: begin
				prdata = tcss_pkg::DATA_W'(cfg_q.beat_length);
			end
			tcss_pkg::REG_BARS_PER_CHORD: begin
				prdata = tcss_pkg::DATA_W'(cfg_q.bars_per_chord);
			end
			tcss_pkg::REG_CLICK_ENABLE: begin
				prdata = tcss_pkg::DATA_W'(cfg_q.click_enable);
			end
			tcss_pkg::REG_AUTO_ROLL_ENABLE: begin
				prdata = tcss_pkg::DATA_W'(cfg_q.auto_roll_enable);
			end
			tcss_pkg::REG_AUTO_ROLL_PASSES: begin
				prdata = tcss_pkg::DATA_W'(cfg_q.auto_roll_passes);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/tcss_core.sv -----
// ---------------------------------------------------------------------------
// tcss_core
// Next-state and result logic for one sample tick of the sequencer.
// ---------------------------------------------------------------------------
module tcss_core (
	input  tcss_pkg::cfg_t    cfg,
	input  tcss_pkg::state_t  st,
	input  tcss_pkg::item_t   item,
	output tcss_pkg::state_t  st_nxt,
	output tcss_pkg::result_t res
);

	logic [tcss_pkg::BEAT_WIDTH-1:0] beat_len;
	logic [tcss_pkg::BARS_W-1:0]     bars;
	logic [tcss_pkg::CNT_W-1:0]      chord_len;
	logic [tcss_pkg::LEN_W-1:0]      pos_inc;
	logic [tcss_pkg::LEN_W-1:0]      last_pos;
	logic [tcss_pkg::PASS_W:0]       passes_plus;
	logic                            run;
	tcss_pkg::state_t                s;

	always_comb begin
		beat_len = (cfg.beat_length == '0) ? tcss_pkg::BEAT_WIDTH'(1) : cfg.beat_length;
		if (cfg.bars_per_chord == '0) begin
			bars = tcss_pkg::BARS_W'(1);
		end else if (cfg.bars_per_chord > tcss_pkg::BARS_W'(4)) begin
			bars = tcss_pkg::BARS_W'(4);
		end else begin
			bars = cfg.bars_per_chord;
		end
		chord_len = (tcss_pkg::CNT_W'(beat_len) * tcss_pkg::CNT_W'(bars)) << 2;
	end

	always_comb begin
		s           = st;
		res         = '0;
		res.position = tcss_pkg::POS_NONE;
		run         = 1'b0;
		pos_inc     = '0;
		last_pos    = s.loop_length - tcss_pkg::LEN_W'(1);
		passes_plus = '0;

		if (item.new_loop_valid) begin
			s.waiting_length = (item.new_loop_length > tcss_pkg::MAX_LEN) ?
				tcss_pkg::MAX_LEN : item.new_loop_length;
			s.waiting_valid  = 1'b1;
			s.roll_pending   = 1'b0;
		end

		if (item.transport_on && !s.was_playing) begin
			s.chord_position     = '0;
			s.chord_sample_count = '0;
			s.beat_sample_count  = '0;
			s.passes_done        = '0;
			if (s.waiting_valid) begin
				s.loop_length   = s.waiting_length;
				s.waiting_valid = 1'b0;
			end
		end
		if (!item.transport_on && s.was_playing) begin
			res.silence    = 1'b1;
			s.roll_pending = 1'b0;
		end
		s.was_playing = item.transport_on;

		if (item.panic) begin
			res.silence = 1'b1;
		end

		if (item.jump_valid && item.transport_on) begin
			if (s.waiting_valid) begin
				s.loop_length   = s.waiting_length;
				s.waiting_valid = 1'b0;
			end
			if (s.loop_length != '0) begin
				last_pos = s.loop_length - tcss_pkg::LEN_W'(1);
				s.chord_position = ({1'b0, item.jump_target} < last_pos) ?
					item.jump_target : last_pos[tcss_pkg::POS_W-1:0];
				s.chord_sample_count = '0;
			end
		end

		if (item.transport_on && !item.hold_time &&
			!(s.loop_length == '0 && !s.waiting_valid)) begin
			run = 1'b1;
			if (s.chord_sample_count == '0) begin
				if (s.waiting_valid) begin
					s.loop_length    = s.waiting_length;
					s.waiting_valid  = 1'b0;
					s.chord_position = '0;
					s.passes_done    = '0;
				end
				if (s.loop_length == '0) begin
					run = 1'b0;
				end else begin
					if ({1'b0, s.chord_position} >= s.loop_length) begin
						s.chord_position = '0;
					end
					res.strike          = 1'b1;
					res.strike_index    = s.chord_position;
					s.beat_sample_count = '0;
				end
			end
			if (run) begin
				if (s.beat_sample_count >= beat_len) begin
					s.beat_sample_count = '0;
				end
				if (s.beat_sample_count == '0 && cfg.click_enable) begin
					res.click        = 1'b1;
					res.click_accent = (s.chord_sample_count == '0);
				end
				s.chord_sample_count = s.chord_sample_count + tcss_pkg::CNT_W'(1);
				s.beat_sample_count  = s.beat_sample_count + tcss_pkg::BEAT_WIDTH'(1);

				last_pos    = s.loop_length - tcss_pkg::LEN_W'(1);
				passes_plus = {1'b0, s.passes_done} + (tcss_pkg::PASS_W + 1)'(1);
				if (cfg.auto_roll_enable && !s.roll_pending && !s.waiting_valid &&
					s.beat_sample_count == tcss_pkg::BEAT_WIDTH'(1) &&
					s.chord_sample_count == tcss_pkg::CNT_W'(1) &&
					{1'b0, s.chord_position} == last_pos &&
					passes_plus >= {1'b0, cfg.auto_roll_passes}) begin
					s.roll_pending   = 1'b1;
					res.roll_request = 1'b1;
				end

				if (s.chord_sample_count >= chord_len) begin
					s.chord_sample_count = '0;
					pos_inc = {1'b0, s.chord_position} + tcss_pkg::LEN_W'(1);
					if (pos_inc >= s.loop_length) begin
						s.chord_position = '0;
						if (s.passes_done != tcss_pkg::PASSES_MAX) begin
							s.passes_done = s.passes_done + tcss_pkg::PASS_W'(1);
						end
					end else begin
						s.chord_position = pos_inc[tcss_pkg::POS_W-1:0];
					end
				end
			end
		end

		if (item.transport_on) begin
			if (s.loop_length != '0) begin
				res.position = {1'b0, s.chord_position};
			end
			res.chord_progress = s.chord_sample_count[tcss_pkg::PROG_W-1:0];
		end

		st_nxt = s;
	end

endmodule
